/* sv/wuws_pkg.sv */
// Shared types, codes and constants of the weighted unit work scheduler.
`default_nettype none

package wuws_pkg;

    localparam int WUWS_MAX_JOBS = 64;
    localparam int WUWS_PENALTY_W = 38;

    // Command codes carried in the func field
    localparam logic [1:0] FUNC_ARRIVE = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] work_units;
        logic [15:0] weight;
    } req_t;

    typedef struct packed {
        logic                      served;
        logic [15:0]               served_weight;
        logic                      dropped;
        logic [WUWS_PENALTY_W-1:0] penalty_total;
    } rsp_t;

    // Weight above units, so a plain compare orders by weight then units
    typedef struct packed {
        logic [15:0] weight;
        logic [15:0] units;
    } key_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_SERVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     new_key;
        key_t     head_key;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_REPORT
    } state_t;

endpackage

`default_nettype wire

/* sv/wuws_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface wuws_stream_if #(
    parameter type payload_t = logic [0:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/wuws_cell.sv */
// One cell of the sorted job chain: holds a single job entry.
`default_nettype none

module wuws_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wuws_pkg::cell_ctl_t ctl,
    input  wire wuws_pkg::key_t    left_key,
    input  wire logic              left_valid,
    input  wire logic              left_gb,
    input  wire wuws_pkg::key_t    right_key,
    input  wire logic              right_valid,
    input  wire logic              right_eq,
    output wuws_pkg::key_t         key,
    output logic                   valid,
    output logic                   gb,
    output logic                   eq
);
    import wuws_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;

    // New job belongs in front of this entry
    assign gb = !valid_reg || (ctl.new_key > key_reg);
    // Entry matches the head of the chain
    assign eq = valid_reg && (key_reg == ctl.head_key);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (left_gb)
                begin
                    key_next   = left_key;
                    valid_next = left_valid;
                end
                else if (gb)
                begin
                    key_next   = ctl.new_key;
                    valid_next = 1'b1;
                end
            end
            OP_POP:
            begin
                key_next   = right_key;
                valid_next = right_valid;
            end
            OP_SERVE:
            begin
                // Decrement the last of the run equal to the head, keeping order
                if (eq && !right_eq)
                begin
                    key_next.units = key_reg.units - 16'd1;
                end
            end
            default:
            begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

/* sv/wuws_penalty_acc.sv */
// Penalty accumulator: registered weight-by-units product and saturating sum.
`default_nettype none

module wuws_penalty_acc (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic                             take,
    input  wire wuws_pkg::key_t                   head_key,
    output logic [wuws_pkg::WUWS_PENALTY_W-1:0]   total
);
    import wuws_pkg::*;

    logic [31:0]               prod_reg;
    logic [31:0]               prod_next;
    logic                      prod_vld_reg;
    logic                      prod_vld_next;
    logic [WUWS_PENALTY_W-1:0] acc_reg;
    logic [WUWS_PENALTY_W-1:0] acc_next;
    logic [WUWS_PENALTY_W:0]   sum;

    assign sum = {1'b0, acc_reg} + {{(WUWS_PENALTY_W - 31){1'b0}}, prod_reg};

    always_comb
    begin
        prod_next     = prod_reg;
        prod_vld_next = take;
        if (take)
        begin
            prod_next = 32'(head_key.weight) * 32'(head_key.units);
        end
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            // Saturate at the top of the range
            acc_next = sum[WUWS_PENALTY_W] ? '1 : sum[WUWS_PENALTY_W-1:0];
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign total = acc_reg;

endmodule

`default_nettype wire

/* sv/weighted_unit_work_scheduler_core.sv */
// Top level of the weighted unit work scheduler: cell chain, control and result register.
//
//  Channel | Dir | Payload                                          | Handshake
//  --------+-----+--------------------------------------------------+-------------
//  cmd     | in  | func, work_units, weight                         | valid/ready
//  res     | out | served, served_weight, dropped, penalty_total    | valid/ready
//
//  Arrival and tick are applied in the sorted cell chain; a result beat is shown
//  the cycle after its command beat, so one command a cycle is taken while results are taken.
//  Finish drains the chain: it shifts out one job a cycle into the multiplier,
//  then the saturating sum settles and the result is loaded.
//  Reset empties the chain at once through the per-cell valid bits.
//  A stalled result holds; a new command is taken once the result slot frees.
`default_nettype none

module weighted_unit_work_scheduler_core #(
    parameter int MAX_JOBS = wuws_pkg::WUWS_MAX_JOBS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    wuws_stream_if.sink        cmd,
    wuws_stream_if.source      res
);
    import wuws_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    req_t                req;
    logic                accept;
    logic                full;
    cell_ctl_t           ctl;
    logic                acc_clear;
    logic                acc_take;
    logic [WUWS_PENALTY_W-1:0] total;

    key_t                cell_key   [MAX_JOBS];
    logic [MAX_JOBS-1:0] cell_valid;
    logic [MAX_JOBS-1:0] cell_gb;
    logic [MAX_JOBS-1:0] cell_eq;

    assign req       = cmd.data;
    assign cmd.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(MAX_JOBS));

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++)
        begin : g_cell
            key_t left_key;
            logic left_valid;
            logic left_gb;
            key_t right_key;
            logic right_valid;
            logic right_eq;

            if (gi == 0)
            begin : g_first
                assign left_key   = '0;
                assign left_valid = 1'b0;
                assign left_gb    = 1'b0;
            end
            else
            begin : g_mid_l
                assign left_key   = cell_key[gi-1];
                assign left_valid = cell_valid[gi-1];
                assign left_gb    = cell_gb[gi-1];
            end

            if (gi == MAX_JOBS - 1)
            begin : g_last
                assign right_key   = '0;
                assign right_valid = 1'b0;
                assign right_eq    = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_key   = cell_key[gi+1];
                assign right_valid = cell_valid[gi+1];
                assign right_eq    = cell_eq[gi+1];
            end

            wuws_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_key    (left_key),
                .left_valid  (left_valid),
                .left_gb     (left_gb),
                .right_key   (right_key),
                .right_valid (right_valid),
                .right_eq    (right_eq),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .gb          (cell_gb[gi]),
                .eq          (cell_eq[gi])
            );
        end
    endgenerate

    wuws_penalty_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (acc_clear),
        .take     (acc_take),
        .head_key (cell_key[0]),
        .total    (total)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.func == FUNC_FINISH))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        ctl.op         = OP_HOLD;
        ctl.new_key    = {req.weight, req.work_units};
        ctl.head_key   = cell_key[0];
        count_next     = count_reg;
        acc_clear      = 1'b0;
        acc_take       = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !res.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next       = '0;
                    rsp_valid_next = 1'b1;
                    case (req.func)
                        FUNC_ARRIVE:
                        begin
                            // Zero-unit arrivals leave no trace
                            if (req.work_units != 16'd0)
                            begin
                                if (full)
                                begin
                                    rsp_next.dropped = 1'b1;
                                end
                                else
                                begin
                                    ctl.op     = OP_INSERT;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        FUNC_TICK:
                        begin
                            if (cell_valid[0])
                            begin
                                rsp_next.served        = 1'b1;
                                rsp_next.served_weight = cell_key[0].weight;
                                if (cell_key[0].units <= 16'd1)
                                begin
                                    ctl.op     = OP_POP;
                                    count_next = count_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    ctl.op = OP_SERVE;
                                end
                            end
                        end
                        FUNC_FINISH:
                        begin
                            // Result follows once the chain has drained
                            rsp_valid_next = 1'b0;
                            acc_clear      = 1'b1;
                        end
                        default:
                        begin
                            rsp_next = '0;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (count_reg != '0)
                begin
                    ctl.op     = OP_POP;
                    acc_take   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_REPORT:
            begin
                rsp_next               = '0;
                rsp_next.penalty_total = total;
                rsp_valid_next         = 1'b1;
            end
            default:
            begin
                ctl.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign res.valid = rsp_valid_reg;
    assign res.data  = rsp_reg;

    // Occupied cells always form a prefix whose size is the job count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with job count");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count beyond store depth");

    // Head of the chain is never below its neighbour
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_key[0] >= cell_key[1]))
        else $error("cell chain out of order at head");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> (count_reg == '0) && !rsp_valid_reg)
        else $error("report with jobs left or result slot busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.ready)
        else $error("command taken while draining");

endmodule

`default_nettype wire

/* tb/weighted_unit_work_scheduler_core_tb.sv */
// Self-checking testbench for the weighted unit work scheduler core.
`timescale 1ns / 1ps

module weighted_unit_work_scheduler_core_tb;

    import wuws_pkg::*;

    localparam logic [1:0]  FUNC_SPARE    = 2'd3;
    localparam logic [39:0] PENALTY_CAP   = (40'd1 << WUWS_PENALTY_W) - 40'd1;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = WUWS_MAX_JOBS + 8;
    localparam int          CALM_TAIL     = 60;
    localparam int          HOLD_AT_BEAT  = 150;
    localparam int          HOLD_CYCLES   = 160;
    localparam int          TARGET_ITEMS  = 550;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    wuws_stream_if #(.payload_t(req_t)) cmd_if ();
    wuws_stream_if #(.payload_t(rsp_t)) res_if ();

    weighted_unit_work_scheduler_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .res   (res_if.source)
    );

    req_t        cmd_backlog [$];
    rsp_t        outcome_q [$];
    logic [15:0] slot_weight [WUWS_MAX_JOBS];
    logic [15:0] slot_units [WUWS_MAX_JOBS];
    int          job_total = 0;
    int          mismatches = 0;
    int          cycle_no = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          beats_taken = 0;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch @%0t beat %0d: %s got 0x%0h want 0x%0h",
                 $time, beats_taken, field, got, want);
    endtask

    task automatic queue_cmd(input logic [1:0] f, input logic [15:0] u, input logic [15:0] w);
        req_t r;
        r.func       = f;
        r.work_units = u;
        r.weight     = w;
        cmd_backlog.push_back(r);
    endtask

    // Advance the scheduler state by one command and return the result it owes
    function automatic rsp_t apply_command(input req_t c);
        rsp_t        r;
        int          best;
        logic [39:0] acc;
        r    = '0;
        best = 0;
        acc  = '0;
        case (c.func)
            FUNC_ARRIVE:
            begin
                if (c.work_units != 16'd0)
                begin
                    if (job_total >= WUWS_MAX_JOBS)
                        r.dropped = 1'b1;
                    else
                    begin
                        slot_weight[job_total] = c.weight;
                        slot_units[job_total]  = c.work_units;
                        job_total++;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (job_total != 0)
                begin
                    for (int i = 1; i < job_total; i++)
                        if ({slot_weight[i], slot_units[i]} >
                            {slot_weight[best], slot_units[best]})
                            best = i;
                    r.served        = 1'b1;
                    r.served_weight = slot_weight[best];
                    if (slot_units[best] <= 16'd1)
                    begin
                        slot_weight[best] = slot_weight[job_total - 1];
                        slot_units[best]  = slot_units[job_total - 1];
                        job_total--;
                    end
                    else
                        slot_units[best] = slot_units[best] - 16'd1;
                end
            end
            FUNC_FINISH:
            begin
                for (int i = 0; i < job_total; i++)
                begin
                    acc = acc + 40'(slot_weight[i]) * 40'(slot_units[i]);
                    if (acc > PENALTY_CAP)
                        acc = PENALTY_CAP;
                end
                r.penalty_total = acc[WUWS_PENALTY_W-1:0];
                job_total = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle windows alternate with quiet stretches; the tail of the run has none
    function automatic bit idling_allowed();
        return ((cycle_no / 64) % 3 != 0) && (cmd_backlog.size() >= CALM_TAIL);
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Command driver: hold valid until the beat is taken, then advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.data  <= '0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                outcome_q.push_back(apply_command(cmd_if.data));
                void'(cmd_backlog.pop_front());
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end
                else if (cmd_backlog.size() == 0)
                    cmd_if.valid <= 1'b0;
                else if (idling_allowed() && $urandom_range(0, 4) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                    cmd_if.valid <= 1'b0;
                end
                else
                begin
                    cmd_if.valid <= 1'b1;
                    cmd_if.data  <= cmd_backlog[0];
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rsp_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("unexpected result", 64'(res_if.data), 64'd0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (res_if.data.served !== want.served)
                        report_mismatch("served", 64'(res_if.data.served), 64'(want.served));
                    if (res_if.data.served_weight !== want.served_weight)
                        report_mismatch("served_weight", 64'(res_if.data.served_weight),
                                        64'(want.served_weight));
                    if (res_if.data.dropped !== want.dropped)
                        report_mismatch("dropped", 64'(res_if.data.dropped), 64'(want.dropped));
                    if (res_if.data.penalty_total !== want.penalty_total)
                        report_mismatch("penalty_total", 64'(res_if.data.penalty_total),
                                        64'(want.penalty_total));
                end
                beats_taken++;
            end
            // Hold off once for a long stretch so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (!hold_done && beats_taken >= HOLD_AT_BEAT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_no <= cycle_no + 1;
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int  kind;
        int  n_jobs;
        bit  wide;
        bit  filled_once;
        logic [15:0] u;
        logic [15:0] w;

        filled_once = 1'b0;
        rst_n = 1'b0;

        // Directed part: empty store, spare code, zero units, extremes, ties
        queue_cmd(FUNC_FINISH, 16'h0000, 16'h0000);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_SPARE,  16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_ARRIVE, 16'h0000, 16'hFFFF);
        queue_cmd(FUNC_ARRIVE, 16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_ARRIVE, 16'h0001, 16'h0000);
        queue_cmd(FUNC_ARRIVE, 16'h0002, 16'h8000);
        queue_cmd(FUNC_ARRIVE, 16'h0003, 16'h8000);
        queue_cmd(FUNC_ARRIVE, 16'h0003, 16'h8000);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_SPARE,  16'h5555, 16'hAAAA);
        queue_cmd(FUNC_FINISH, 16'h0000, 16'h0000);
        queue_cmd(FUNC_ARRIVE, 16'h0001, 16'h0005);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_TICK,   16'h0000, 16'h0000);
        queue_cmd(FUNC_ARRIVE, 16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_ARRIVE, 16'h5555, 16'hAAAA);
        queue_cmd(FUNC_ARRIVE, 16'hAAAA, 16'h5555);
        queue_cmd(FUNC_FINISH, 16'h0000, 16'h0000);

        // Random part: mostly job batches closed by a finish, some fills, some noise
        while (cmd_backlog.size() < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (!filled_once || kind < 8)
            begin
                filled_once = 1'b1;
                for (int i = 0; i < WUWS_MAX_JOBS + $urandom_range(1, 4); i++)
                begin
                    u = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
                    queue_cmd(FUNC_ARRIVE, u, 16'($urandom));
                end
                queue_cmd(FUNC_TICK, 16'($urandom), 16'($urandom));
                queue_cmd(FUNC_ARRIVE, 16'($urandom_range(1, 65535)), 16'($urandom));
                queue_cmd(FUNC_ARRIVE, 16'($urandom_range(1, 65535)), 16'($urandom));
                queue_cmd(FUNC_FINISH, 16'($urandom), 16'($urandom));
            end
            else if (kind < 85)
            begin
                n_jobs = $urandom_range(1, 12);
                wide   = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < n_jobs; i++)
                begin
                    u = wide ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 4));
                    w = wide ? 16'($urandom) : 16'($urandom_range(0, 3));
                    if ($urandom_range(0, 15) == 0)
                        u = 16'h0000;
                    queue_cmd(FUNC_ARRIVE, u, w);
                    repeat ($urandom_range(0, 2))
                        queue_cmd(FUNC_TICK, 16'($urandom), 16'($urandom));
                end
                repeat ($urandom_range(0, 2 * n_jobs))
                    queue_cmd(FUNC_TICK, 16'($urandom), 16'($urandom));
                if ($urandom_range(0, 4) != 0)
                    queue_cmd(FUNC_FINISH, 16'($urandom), 16'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    queue_cmd(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (outcome_q.size() != 0)
            report_mismatch("results left over", 64'(outcome_q.size()), 64'd0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
